/* hdl/jwli_pkg.sv */
`timescale 1ns / 1ps
package jwli_pkg;
    localparam int JOINTS = 7;
    localparam int JW = 3;
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_WAYPOINT = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic CFG_MAX_VELOCITY = 1'b0;
    localparam logic CFG_CONTROL_PERIOD = 1'b1;
endpackage

/* hdl/joint_waypoint_linear_interpolator_core.sv */
`timescale 1ns / 1ps
// Seven-joint waypoint interpolator, Q3.12 fixed point.
// Input beats on s_axis: tuser is the 2-bit command (0 start, 1 waypoint,
// 2 tick), tdata carries the seven joint positions, joint 0 lowest.
// Output beats on m_axis: one per joint on a tick, tlast on the seventh.
// Configuration: i_cfg_we, i_cfg_index (0 max_velocity, 1 control_period).
// One divider, shared by every quotient, retires one bit a cycle (50 bits for
// the duration, 33 or 32 bits per joint velocity, 33 bits per joint position).
// A start beat frees the input on the next cycle; a waypoint with no segment
// active first finds the largest move one joint at a time, then divides for
// the duration and for each joint velocity in turn, and returns to idle after
// the search when no joint moves. A running tick divides for each joint position
// in turn and a holding tick sends the held positions, each joint result leaving as soon as it is ready.
// The block takes no beat while busy. When the receiver stalls a result is
// held in the output register and the sequencer waits.
// Reset restores the register defaults and clears the previous, start, delta and velocity state of every joint.
module joint_waypoint_linear_interpolator_core
    import jwli_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // joint_0_position .. joint_6_position, 16 bits each
    input  logic [111:0] s_axis_tdata,
    // command
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // joint_number, target_position, target_velocity, pad
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    // segment_done, holding
    output logic [1:0]   m_axis_tuser
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_MAX = 7'b0000010, S_QDIV = 7'b0000100,
        S_VDIV = 7'b0001000, S_PDIV = 7'b0010000, S_EMIT = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

    t_state r_state;
    logic [14:0] r_mv;
    logic [15:0] r_cp;
    logic signed [15:0] r_prev [JOINTS];
    logic signed [15:0] r_start [JOINTS];
    logic signed [16:0] r_delta [JOINTS];
    logic signed [15:0] r_vel [JOINTS];
    logic signed [15:0] r_end [JOINTS];
    logic [15:0] r_sidx, r_stot;
    logic r_active, r_done, r_clamp;
    logic [JW-1:0] r_j;
    logic [16:0] r_m;
    // Shared restoring divider: remainder, quotient, divisor, count.
    logic [49:0] r_quo;
    logic [50:0] r_rem;
    logic [33:0] r_den;
    logic [5:0] r_cnt;
    logic r_neg;
    logic [39:0] r_odata;
    logic [1:0] r_ouser;
    logic r_olast, r_ovalid;

    logic [14:0] w_mv;
    logic [15:0] w_cp;
    logic [16:0] w_d, w_a;
    logic [50:0] w_rem;
    logic w_ge;
    logic signed [16:0] w_qv;
    logic signed [17:0] w_pos;
    logic signed [33:0] w_prod;
    logic [33:0] w_pmag;

    assign w_mv = (r_mv == '0) ? 15'd1 : r_mv;
    assign w_cp = (r_cp == '0) ? 16'd1 : r_cp;
    assign w_d = 17'({r_end[r_j][15], r_end[r_j]} - {r_prev[r_j][15], r_prev[r_j]});
    assign w_a = w_d[16] ? 17'(-w_d) : w_d;
    assign w_rem = {r_rem[49:0], r_quo[49]};
    assign w_ge = w_rem >= {17'd0, r_den};
    // Signed position quotient, from the low 17 bits of the divider quotient.
    assign w_qv = r_neg ? 17'(-r_quo[16:0]) : r_quo[16:0];
    assign w_pos = 18'(r_start[r_j]) + 18'(w_qv);
    assign w_prod = r_delta[r_j] * $signed({1'b0, r_sidx});
    assign w_pmag = w_prod[33] ? 34'(-w_prod) : 34'(w_prod);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tlast = r_olast;
    assign m_axis_tuser = r_ouser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mv <= 15'd819;
            r_cp <= 16'd1311;
            r_sidx <= '0;
            r_stot <= 16'd1;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
            r_j <= '0;
            for (int k = 0; k < JOINTS; k++) begin
                r_prev[k] <= '0;
                r_start[k] <= '0;
                r_delta[k] <= '0;
                r_vel[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_VELOCITY) r_mv <= i_cfg_data[14:0];
                else r_cp <= i_cfg_data;
            end
            // The output register fills from the emit state and empties on a beat.
            if (r_state == S_EMIT && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        for (int k = 0; k < JOINTS; k++)
                            r_end[k] <= s_axis_tdata[16*k +: 16];
                        r_j <= '0;
                        r_m <= '0;
                        if (s_axis_tuser == CMD_START) begin
                            if (!r_active)
                                for (int k = 0; k < JOINTS; k++)
                                    r_prev[k] <= s_axis_tdata[16*k +: 16];
                        end else if (s_axis_tuser == CMD_WAYPOINT) begin
                            if (!r_active) r_state <= S_MAX;
                        end else if (s_axis_tuser == CMD_TICK) begin
                            if (r_active) begin
                                if (r_sidx < r_stot) begin
                                    r_sidx <= r_sidx + 16'd1;
                                    r_done <= (r_sidx + 16'd1) >= r_stot;
                                end else begin
                                    r_done <= 1'b1;
                                end
                                r_state <= S_WAIT;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end
                // Largest joint move, one joint per cycle.
                S_MAX: begin
                    r_delta[r_j] <= w_d;
                    if (w_a > r_m) r_m <= w_a;
                    if (r_j == JW'(JOINTS - 1)) begin
                        r_j <= '0;
                        if (w_a == '0 && r_m == '0) begin
                            for (int k = 0; k < JOINTS; k++) r_prev[k] <= r_end[k];
                            r_state <= S_IDLE;
                        end else begin
                            r_quo <= {1'b0, (w_a > r_m ? w_a[15:0] : r_m[15:0]), 33'd0};
                            r_rem <= '0;
                            r_den <= 34'({w_mv} * {w_cp});
                            r_cnt <= 6'd50;
                            r_state <= S_QDIV;
                        end
                    end else begin
                        r_j <= r_j + JW'(1);
                    end
                end
                // Duration m * 2^16 / (mv * cp), in periods.
                S_QDIV: begin
                    r_rem <= w_ge ? 51'(w_rem - {17'd0, r_den}) : w_rem;
                    r_quo <= {r_quo[48:0], w_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        // Quotient holds (m<<33)/den; duration = it >> 17.
                        r_clamp <= ({r_quo[48:0], w_ge} >> 17) == 50'd0;
                        if (({r_quo[48:0], w_ge} >> 17) == 50'd0) r_stot <= 16'd1;
                        else if (({r_quo[48:0], w_ge} >> 17) > 50'd65535)
                            r_stot <= 16'hFFFF;
                        else r_stot <= 16'({r_quo[48:0], w_ge} >> 17);
                        r_j <= '0;
                        r_state <= S_VDIV;
                    end
                end
                // Per joint velocity: |d|*2^16/cp or |d|*mv/m.
                S_VDIV: begin
                    if (r_cnt == '0) begin
                        r_neg <= r_delta[r_j][16];
                        r_rem <= '0;
                        r_quo <= r_clamp
                            ? {r_delta[r_j][16] ? 17'(-r_delta[r_j]) : r_delta[r_j], 33'd0}
                            : {32'(r_delta[r_j][16] ? 17'(-r_delta[r_j]) : r_delta[r_j])
                               * 32'(w_mv), 18'd0};
                        r_den <= r_clamp ? {18'd0, w_cp} : {17'd0, r_m};
                        r_cnt <= r_clamp ? 6'd33 : 6'd32;
                    end else begin
                        r_rem <= w_ge ? 51'(w_rem - {17'd0, r_den}) : w_rem;
                        r_quo <= {r_quo[48:0], w_ge};
                        r_cnt <= r_cnt - 6'd1;
                        if (r_cnt == 6'd1) begin
                            r_start[r_j] <= r_prev[r_j];
                            r_prev[r_j] <= r_end[r_j];
                            if ({r_quo[30:0], w_ge} > 32'(r_neg ? 32768 : 32767))
                                r_vel[r_j] <= r_neg ? -16'sd32768 : 16'sd32767;
                            else r_vel[r_j] <= r_neg ? 16'(-{r_quo[14:0], w_ge})
                                                     : 16'({r_quo[14:0], w_ge});
                            if (r_j == JW'(JOINTS - 1)) begin
                                r_j <= '0;
                                r_sidx <= '0;
                                r_active <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_j <= r_j + JW'(1);
                            end
                        end
                    end
                end
                // Wait for the output register, then start a position quotient.
                S_WAIT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        if (!r_active) r_state <= S_EMIT;
                        else begin
                            r_neg <= w_prod[33];
                            r_rem <= '0;
                            r_quo <= {w_pmag[32:0], 17'd0};
                            r_den <= {18'd0, r_stot};
                            r_cnt <= 6'd33;
                            r_state <= S_PDIV;
                        end
                    end
                end
                S_PDIV: begin
                    r_rem <= w_ge ? 51'(w_rem - {17'd0, r_den}) : w_rem;
                    r_quo <= {r_quo[48:0], w_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) r_state <= S_EMIT;
                end
                // Load one joint result into the output register.
                S_EMIT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_olast <= (r_j == JW'(JOINTS - 1));
                        if (r_active) begin
                            r_odata <= {5'd0, r_vel[r_j],
                                w_pos > 18'sd32767 ? 16'h7FFF :
                                w_pos < -18'sd32768 ? 16'h8000 : w_pos[15:0],
                                r_j};
                            r_ouser <= {1'b0, r_done};
                        end else begin
                            r_odata <= {5'd0, 16'd0, r_prev[r_j], r_j};
                            r_ouser <= 2'b10;
                        end
                        if (r_j == JW'(JOINTS - 1)) begin
                            r_j <= '0;
                            if (r_active && r_done) r_active <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_j <= r_j + JW'(1);
                            r_state <= r_active ? S_WAIT : S_EMIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
